// File: sv/gbia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped bitmap inode allocator package
// Sizes, codes and the sequencer state type shared by the allocator files.
// ----------------------------------------------------------------------------
package gbia_pkg;

  localparam int MAX_GROUPS    = 8;
  localparam int MAX_PER_GROUP = 256;

  // Bitmap storage: one byte holds eight usage bits.
  localparam int BYTES_PER_GRP = MAX_PER_GROUP / 8;
  localparam int BITMAP_BYTES  = MAX_GROUPS * BYTES_PER_GRP;
  localparam int GRP_W         = $clog2(MAX_GROUPS);
  localparam int BYTE_W        = $clog2(BYTES_PER_GRP);
  localparam int BADDR_W       = GRP_W + BYTE_W;
  localparam int BIT_W         = BYTE_W + 3;

  localparam int NUM_W    = 12;
  localparam int CNT_W    = 9;
  localparam int NG_W     = 4;
  localparam int STEP_W   = 4;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [NUM_W-1:0] TOTAL_MAX = NUM_W'(MAX_GROUPS * MAX_PER_GROUP);
  localparam logic [CNT_W-1:0] PER_MAX   = CNT_W'(MAX_PER_GROUP);
  localparam logic [NG_W-1:0]  NG_MAX    = NG_W'(MAX_GROUPS);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_READY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS = 2'd2;

  // Request kinds.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AL_GRP,
    S_AL_RD,
    S_AL_CHK,
    S_DIV,
    S_LOC,
    S_RD,
    S_MOD,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// File: sv/grouped_bitmap_inode_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped bitmap inode allocator
// First-fit inode allocator over a grouped usage bitmap with per-group and
// total free counts, driven by a small sequencer around one bitmap RAM.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | tuser[1:0] func, tdata[11:0] inode_number
// m_axis   | out       | tdata[11:0] allocated_number, [13:12] status,
//          |           | [25:14] total_free
// cfg      | in        | we, index (0 ready, 1 per-group, 2 group count), data
//
// An alloc reads and checks the bitmap one byte at a time through the single
// RAM port and passes over a group whose free count is zero without reading.
// Free and mark run a 12-step restoring divider and a read-modify-write.
// Clear, any request while not mounted and a free or mark of number zero
// go straight to the result; a number whose group is out of range is
// turned away once the divider has finished.
// Reset marks every bitmap byte not valid, so it reads as all free; there
// is no clearing pass. A result waits in the output register while the
// next item is accepted; the sequencer only stalls when that slot is full.
// ----------------------------------------------------------------------------
module grouped_bitmap_inode_allocator_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [gbia_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [gbia_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Request stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [15:0]                      s_axis_tdata,  // [11:0] inode_number
  input  wire logic [gbia_pkg::FUNC_W-1:0]      s_axis_tuser,  // [1:0] func
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [31:0]                           m_axis_tdata   // [11:0] allocated_number,
                                                               // [13:12] status,
                                                               // [25:14] total_free
);

  import gbia_pkg::*;

  // Configuration registers.
  logic             ready_q;
  logic [CNT_W-1:0] per_cfg_q;
  logic [NG_W-1:0]  ng_cfg_q;

  // Sequencer and datapath registers.
  state_e               state_q, state_d;
  logic [FUNC_W-1:0]    func_q, func_d;
  logic [NG_W-1:0]      g_q, g_d;
  logic [BYTE_W-1:0]    j_q, j_d;
  logic [NUM_W-1:0]     base_q, base_d;
  logic [NUM_W-1:0]     quo_q, quo_d;
  logic [BIT_W-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [NUM_W-1:0]     res_num_q, res_num_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;

  // Free counts and bitmap byte valid flags.
  logic [CNT_W-1:0]        gcnt_q [MAX_GROUPS];
  logic [CNT_W-1:0]        gcnt_d [MAX_GROUPS];
  logic [NUM_W-1:0]        total_q, total_d;
  logic [BITMAP_BYTES-1:0] valid_q, valid_d;
  logic                    rd_valid_q;

  // Output register.
  logic              m_valid_q, m_valid_d;
  logic [NUM_W-1:0]  m_num_q, m_num_d;
  logic [STATUS_W-1:0] m_status_q, m_status_d;
  logic [NUM_W-1:0]  m_total_q, m_total_d;

  // RAM port.
  logic [BADDR_W-1:0] ram_addr;
  logic               ram_we;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  // Effective configuration: per-group count clamped to 1..MAX, groups to MAX.
  logic [CNT_W-1:0] eff_per;
  logic [NG_W-1:0]  eff_ng;

  always_comb begin
    if (per_cfg_q == '0) begin
      eff_per = CNT_W'(1);
    end else if (per_cfg_q > PER_MAX) begin
      eff_per = PER_MAX;
    end else begin
      eff_per = per_cfg_q;
    end
    eff_ng = (ng_cfg_q > NG_MAX) ? NG_MAX : ng_cfg_q;
  end

  // Handshake helpers.
  logic s_fire, out_free;
  logic [FUNC_W-1:0] in_func;
  logic [NUM_W-1:0]  in_ino;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign in_func       = s_axis_tuser;
  assign in_ino        = s_axis_tdata[NUM_W-1:0];

  // A byte never written since reset or the last clear reads as all free.
  logic [7:0] rd_byte;
  assign rd_byte = rd_valid_q ? ram_rdata : 8'h00;

  // Alloc scan: first clear bit of the current byte among bits below the
  // per-group count.
  logic                grp_end, grp_empty, al_hit, al_last;
  logic [2:0]          al_k;
  logic [BIT_W-1:0]    al_pos;
  logic [CNT_W-1:0]    byte_next;

  assign grp_end   = (g_q == eff_ng);
  assign grp_empty = (gcnt_q[g_q[GRP_W-1:0]] == '0);
  assign byte_next = {1'b0, j_q, 3'b000} + CNT_W'(8);
  assign al_last   = (byte_next >= eff_per);

  always_comb begin
    logic [BIT_W-1:0] pos;
    al_hit = 1'b0;
    al_k   = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      pos = {j_q, 3'(k)};
      if (!rd_byte[k] && ({1'b0, pos} < eff_per)) begin
        al_hit = 1'b1;
        al_k   = 3'(k);
      end
    end
  end
  assign al_pos = {j_q, al_k};

  // Restoring divider step: one quotient bit per cycle.
  logic [CNT_W-1:0] div_trial, div_diff;
  logic             div_ge, div_last, loc_ok;

  assign div_trial = {rem_q, quo_q[NUM_W-1]};
  assign div_ge    = (div_trial >= eff_per);
  assign div_diff  = div_trial - eff_per;
  assign div_last  = (step_q == STEP_W'(NUM_W - 1));
  assign loc_ok    = (quo_q < {{(NUM_W-NG_W){1'b0}}, eff_ng});

  // Bit addressed by a free or mark.
  logic [7:0] loc_mask;
  assign loc_mask = 8'(1) << rem_q[2:0];

  // Clear: total is groups in use times the per-group count.
  logic [NG_W+CNT_W-1:0] clr_total;
  assign clr_total = eff_ng * eff_per;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (!ready_q || in_func == FUNC_CLEAR) begin
            state_d = S_DONE;
          end else if (in_func == FUNC_ALLOC) begin
            state_d = S_AL_GRP;
          end else if (in_ino == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_AL_GRP: begin
        if (grp_end) begin
          state_d = S_DONE;
        end else if (!grp_empty) begin
          state_d = S_AL_RD;
        end
      end
      S_AL_RD:  state_d = S_AL_CHK;
      S_AL_CHK: begin
        if (al_hit) begin
          state_d = S_DONE;
        end else if (al_last) begin
          state_d = S_AL_GRP;
        end else begin
          state_d = S_AL_RD;
        end
      end
      S_DIV: begin
        if (div_last) begin
          state_d = S_LOC;
        end
      end
      S_LOC:  state_d = loc_ok ? S_RD : S_DONE;
      S_RD:   state_d = S_MOD;
      S_MOD:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic [CNT_W-1:0] gsel;
    func_d       = func_q;
    g_d          = g_q;
    j_d          = j_q;
    base_d       = base_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    step_d       = step_q;
    res_num_d    = res_num_q;
    res_status_d = res_status_q;
    gcnt_d       = gcnt_q;
    total_d      = total_q;
    valid_d      = valid_q;
    ram_we       = 1'b0;
    ram_wdata    = rd_byte;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_num_d      = m_num_q;
    m_status_d   = m_status_q;
    m_total_d    = m_total_q;
    gsel         = gcnt_q[g_q[GRP_W-1:0]];

    if (state_q == S_AL_GRP || state_q == S_AL_RD || state_q == S_AL_CHK) begin
      ram_addr = {g_q[GRP_W-1:0], j_q};
    end else begin
      ram_addr = {g_q[GRP_W-1:0], rem_q[BIT_W-1:3]};
    end

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          func_d       = in_func;
          res_num_d    = '0;
          res_status_d = STATUS_OK;
          g_d          = '0;
          j_d          = '0;
          base_d       = '0;
          rem_d        = '0;
          step_d       = '0;
          quo_d        = in_ino - NUM_W'(1);
          if (!ready_q) begin
            res_status_d = STATUS_INVALID;
          end else if (in_func == FUNC_CLEAR) begin
            valid_d = '0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
              gcnt_d[g] = (NG_W'(g) < eff_ng) ? eff_per : '0;
            end
            total_d = clr_total[NUM_W-1:0];
          end else if (in_func != FUNC_ALLOC && in_ino == '0) begin
            res_status_d = STATUS_INVALID;
          end
        end
      end
      S_AL_GRP: begin
        if (grp_end) begin
          res_status_d = STATUS_FULL;
        end else if (grp_empty) begin
          g_d    = g_q + NG_W'(1);
          base_d = base_q + {{(NUM_W-CNT_W){1'b0}}, eff_per};
        end else begin
          j_d = '0;
        end
      end
      S_AL_CHK: begin
        if (al_hit) begin
          ram_we    = 1'b1;
          ram_wdata = rd_byte | (8'(1) << al_k);
          valid_d[ram_addr] = 1'b1;
          if (gsel != '0) begin
            gcnt_d[g_q[GRP_W-1:0]] = gsel - CNT_W'(1);
          end
          if (total_q != '0) begin
            total_d = total_q - NUM_W'(1);
          end
          res_num_d = base_q + {{(NUM_W-BIT_W){1'b0}}, al_pos} + NUM_W'(1);
        end else if (al_last) begin
          g_d    = g_q + NG_W'(1);
          base_d = base_q + {{(NUM_W-CNT_W){1'b0}}, eff_per};
        end else begin
          j_d = j_q + BYTE_W'(1);
        end
      end
      S_DIV: begin
        rem_d  = div_ge ? div_diff[BIT_W-1:0] : div_trial[BIT_W-1:0];
        quo_d  = {quo_q[NUM_W-2:0], div_ge};
        step_d = step_q + STEP_W'(1);
      end
      S_LOC: begin
        if (!loc_ok) begin
          res_status_d = STATUS_INVALID;
        end else begin
          g_d = {{(NG_W-GRP_W){1'b0}}, quo_q[GRP_W-1:0]};
        end
      end
      S_MOD: begin
        if (func_q == FUNC_FREE) begin
          // A double free leaves the bit clear but still counts up.
          ram_we    = 1'b1;
          ram_wdata = rd_byte & ~loc_mask;
          valid_d[ram_addr] = 1'b1;
          if (gsel < PER_MAX) begin
            gcnt_d[g_q[GRP_W-1:0]] = gsel + CNT_W'(1);
          end
          if (total_q < TOTAL_MAX) begin
            total_d = total_q + NUM_W'(1);
          end
        end else if ((rd_byte & loc_mask) == 8'h00) begin
          ram_we    = 1'b1;
          ram_wdata = rd_byte | loc_mask;
          valid_d[ram_addr] = 1'b1;
          if (gsel != '0) begin
            gcnt_d[g_q[GRP_W-1:0]] = gsel - CNT_W'(1);
          end
          if (total_q != '0) begin
            total_d = total_q - NUM_W'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_num_d    = res_num_q;
          m_status_d = res_status_q;
          m_total_d  = total_q;
        end
      end
      default: begin
      end
    endcase
  end

  gbia_ram #(
    .WIDTH(8),
    .DEPTH(BITMAP_BYTES)
  ) u_bitmap (
    .clk_i  (clk_i),
    .addr_i (ram_addr),
    .we_i   (ram_we),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ready_q   <= 1'b0;
      per_cfg_q <= PER_MAX;
      ng_cfg_q  <= NG_MAX;
      total_q   <= '0;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
        gcnt_q[g] <= '0;
      end
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      valid_q   <= valid_d;
      m_valid_q <= m_valid_d;
      gcnt_q    <= gcnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_READY:  ready_q   <= cfg_data_i[0];
          CFG_PER:    per_cfg_q <= cfg_data_i;
          CFG_GROUPS: ng_cfg_q  <= cfg_data_i[NG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    g_q          <= g_d;
    j_q          <= j_d;
    base_q       <= base_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    step_q       <= step_d;
    res_num_q    <= res_num_d;
    res_status_q <= res_status_d;
    rd_valid_q   <= valid_q[ram_addr];
    m_num_q      <= m_num_d;
    m_status_q   <= m_status_d;
    m_total_q    <= m_total_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_total_q, m_status_q, m_num_q};

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_MAX)
    else $error("total free count above its maximum");

  a_chk_group_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AL_CHK) |-> (gcnt_q[g_q[GRP_W-1:0]] != '0))
    else $error("alloc scanning a group with no free count");

  a_loc_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOC) |-> ($past(state_q) == S_DIV && $past(div_last)))
    else $error("locate entered before the division finished");

  a_clear_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && ready_q && in_func == FUNC_CLEAR) |=> (valid_q == '0))
    else $error("clear left bitmap bytes marked valid");

  a_full_no_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == STATUS_FULL) |-> (m_num_q == '0))
    else $error("full result carries an inode number");
`endif

endmodule
`default_nettype wire

// File: sv/gbia_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address for read and write, read data registered.
// ----------------------------------------------------------------------------
module gbia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped bitmap inode allocator testbench
// The testbench sends request items on the input stream and models the
// allocator's bitmap and free counts itself. Every result item is checked
// field by field against the predicted reply. The run covers directed corner
// cases and random traffic over several group shapes, with idle cycles and
// back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb;
  import gbia_pkg::*;

  // The receiver holds off for this many cycles when a long stall is asked for.
  localparam int LONG_HOLD     = 200;
  // Cycles left after the last reply before the configuration is touched.
  localparam int SETTLE_CYCLES = 8;
  // Cycles watched after the final reply, which exceed the slowest alloc.
  localparam int TAIL_CYCLES   = 600;

  typedef struct packed {
    logic [NUM_W-1:0]    number;
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    free_total;
  } inode_reply_t;

  // Every input of the block has a known value from time zero.
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_READY;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;  // [11:0] inode_number
  logic [FUNC_W-1:0]     s_axis_tuser  = FUNC_ALLOC;  // [1:0] func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;  // [11:0] allocated_number, [13:12] status,
                                        // [25:14] total_free

  // Our own copy of the allocator: usage bits at their physical place
  // (group * MAX_PER_GROUP + bit), the free counts and the registers.
  bit           inode_used [MAX_GROUPS*MAX_PER_GROUP];
  int unsigned  group_free [MAX_GROUPS];
  int unsigned  free_total;
  bit           mounted;
  int unsigned  per_group_reg;
  int unsigned  group_count_reg;

  inode_reply_t pending_replies[$];
  int unsigned  issued_inodes[$];
  inode_reply_t last_reply;

  bit           offering;
  bit           tx_gaps;
  bit           rx_gaps;
  int unsigned  holds_asked;
  int unsigned  holds_done;
  int unsigned  mismatch_count;
  int unsigned  reply_index;
  int unsigned  requests_by_func [4];
  int unsigned  replies_by_status [4];

  grouped_bitmap_inode_allocator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A per-group size of zero behaves as one, anything above the maximum as
  // the maximum. Group counts above the maximum are clamped likewise.
  function automatic int unsigned used_per_group();
    if (per_group_reg == 0) return 1;
    if (per_group_reg > MAX_PER_GROUP) return MAX_PER_GROUP;
    return per_group_reg;
  endfunction

  function automatic int unsigned used_groups();
    return (group_count_reg > MAX_GROUPS) ? MAX_GROUPS : group_count_reg;
  endfunction

  // Splits a one-based inode number into group and bit. Number zero and
  // numbers beyond the groups in use name no inode.
  function automatic bit split_inode(input int unsigned ino, output int unsigned grp,
                                     output int unsigned idx);
    grp = 0;
    idx = 0;
    if (ino == 0) return 1'b0;
    grp = (ino - 1) / used_per_group();
    idx = (ino - 1) % used_per_group();
    return grp < used_groups();
  endfunction

  // Taking an inode lowers both counts, neither of which goes below zero.
  function automatic void consume_inode(input int unsigned grp);
    if (group_free[grp] > 0) group_free[grp]--;
    if (free_total > 0) free_total--;
  endfunction

  function automatic inode_reply_t predict_reply(input logic [FUNC_W-1:0] func,
                                                 input logic [NUM_W-1:0]  ino);
    inode_reply_t reply;
    int unsigned  per;
    int unsigned  ng;
    int unsigned  grp;
    int unsigned  idx;
    bit           found;
    per          = used_per_group();
    ng           = used_groups();
    reply        = '0;
    reply.status = STATUS_OK;
    found        = 1'b0;
    if (!mounted) begin
      reply.status = STATUS_INVALID;
    end else begin
      case (func)
        FUNC_ALLOC: begin
          // First fit in group order. A group whose count says free but
          // whose bits are all taken is simply passed over.
          for (grp = 0; grp < ng && !found; grp++) begin
            if (group_free[grp] == 0) continue;
            for (idx = 0; idx < per && !found; idx++) begin
              if (!inode_used[grp*MAX_PER_GROUP + idx]) begin
                inode_used[grp*MAX_PER_GROUP + idx] = 1'b1;
                consume_inode(grp);
                reply.number = NUM_W'(grp*per + idx + 1);
                found        = 1'b1;
              end
            end
          end
          if (!found) reply.status = STATUS_FULL;
        end
        FUNC_FREE: begin
          // A double free leaves the bit clear but still raises the counts,
          // up to their saturation limits.
          if (!split_inode(ino, grp, idx)) begin
            reply.status = STATUS_INVALID;
          end else begin
            inode_used[grp*MAX_PER_GROUP + idx] = 1'b0;
            if (group_free[grp] < MAX_PER_GROUP) group_free[grp]++;
            if (free_total < MAX_GROUPS*MAX_PER_GROUP) free_total++;
          end
        end
        FUNC_CLEAR: begin
          foreach (inode_used[i]) inode_used[i] = 1'b0;
          for (grp = 0; grp < MAX_GROUPS; grp++) group_free[grp] = (grp < ng) ? per : 0;
          free_total = ng * per;
        end
        default: begin
          // Marking an inode that is already in use changes nothing.
          if (!split_inode(ino, grp, idx)) begin
            reply.status = STATUS_INVALID;
          end else if (!inode_used[grp*MAX_PER_GROUP + idx]) begin
            inode_used[grp*MAX_PER_GROUP + idx] = 1'b1;
            consume_inode(grp);
          end
        end
      endcase
    end
    reply.free_total = NUM_W'(free_total);
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one request item and waits for it to be taken. Valid stays high
  // afterwards so that back-to-back items need no dead cycle; it is lowered
  // only for an idle burst or when the sender pauses.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [NUM_W-1:0] ino);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      if (offering) begin
        s_axis_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0000, ino};
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    last_reply = predict_reply(func, ino);
    pending_replies.push_back(last_reply);
    requests_by_func[func]++;
    replies_by_status[last_reply.status]++;
  endtask

  // The sender stops and waits until every outstanding reply has arrived.
  // Every item gives exactly one reply, so the block is then idle.
  task automatic wait_all_replies();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk_i); while (pending_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles, only once idle.
  task automatic write_registers(input bit ready, input int unsigned per,
                                 input int unsigned groups);
    wait_all_replies();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_READY;
    cfg_data_i <= CFG_DATA_W'(ready);
    @(posedge clk_i);
    mounted = ready;
    cfg_idx_i  <= CFG_PER;
    cfg_data_i <= CFG_DATA_W'(per);
    @(posedge clk_i);
    per_group_reg = per & 'h1FF;
    cfg_idx_i  <= CFG_GROUPS;
    cfg_data_i <= CFG_DATA_W'(groups);
    @(posedge clk_i);
    group_count_reg = groups & 'hF;
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("reply %0d: %s is %0d, expected %0d",
                                reply_index, name, got, want));
  endtask

  // Each reply taken by the sink is held against the oldest prediction.
  always @(posedge clk_i) begin : reply_check
    inode_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %h arrived with nothing outstanding", m_axis_tdata));
      end else begin
        want = pending_replies.pop_front();
        check_field("allocated_number", m_axis_tdata[11:0], want.number);
        check_field("status", m_axis_tdata[13:12], want.status);
        check_field("total_free", m_axis_tdata[25:14], want.free_total);
      end
      reply_index++;
    end
  end

  // The result sink. It stalls in short random bursts, and for one long
  // stretch whenever a test asks for it, counting the cycles itself.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
        holds_done++;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // While not mounted every kind of request is turned away.
  task automatic test_unmounted();
    write_registers(1'b0, MAX_PER_GROUP, MAX_GROUPS);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_FREE, 12'd1);
    send_request(FUNC_CLEAR, 12'd0);
    send_request(FUNC_MARK, 12'd5);
  endtask

  // Mounted before any clear: the counts start at zero, so alloc reports
  // full, a mark cannot push the counts below zero, and a free makes one
  // inode available again.
  task automatic test_unloaded_bitmap();
    write_registers(1'b1, MAX_PER_GROUP, MAX_GROUPS);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_MARK, 12'd1);
    send_request(FUNC_FREE, 12'd1);
    send_request(FUNC_ALLOC, 12'd0);
  endtask

  // Full size: first fit, reuse of a freed number, invalid numbers, a double
  // free at a saturated group count and a repeated mark.
  task automatic test_first_fit();
    send_request(FUNC_CLEAR, 12'hFFF);
    send_request(FUNC_ALLOC, 12'hFFF);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_FREE, 12'd1);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_FREE, 12'd0);
    send_request(FUNC_FREE, 12'hFFF);
    send_request(FUNC_FREE, 12'd2048);
    send_request(FUNC_MARK, 12'd2048);
    send_request(FUNC_MARK, 12'd2048);
  endtask

  // Odd shapes: one inode in all, a group whose count is stale after a
  // double free, no groups at all, and register values beyond their range.
  task automatic test_group_shapes();
    write_registers(1'b1, 1, 1);
    send_request(FUNC_CLEAR, 12'd0);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_ALLOC, 12'd0);
    write_registers(1'b1, 2, 2);
    send_request(FUNC_CLEAR, 12'd0);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_FREE, 12'd1);
    send_request(FUNC_FREE, 12'd1);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_ALLOC, 12'd0);
    write_registers(1'b1, 0, 0);
    send_request(FUNC_ALLOC, 12'd0);
    send_request(FUNC_MARK, 12'd1);
    write_registers(1'b1, 511, 15);
    send_request(FUNC_CLEAR, 12'd0);
    send_request(FUNC_MARK, 12'd2048);
  endtask

  // The sink stalls for a long stretch while allocs keep coming, so the
  // output slot fills and the block has to hold off its input.
  task automatic test_backpressure();
    write_registers(1'b1, 16, 4);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_request(FUNC_CLEAR, 12'd0);
    holds_asked++;
    repeat (24) send_request(FUNC_ALLOC, NUM_W'($urandom_range(0, 4095)));
    wait_all_replies();
  endtask

  // One phase of random traffic for a given shape. Most items are allocs
  // and frees of numbers handed out earlier; the rest are marks, frees of
  // arbitrary numbers in range, raw 12-bit noise and the odd clear.
  task automatic run_random_phase(input bit ready, input int unsigned per,
                                  input int unsigned groups, input int unsigned items,
                                  input bit gaps);
    int unsigned span;
    int unsigned pick;
    int unsigned slot;
    write_registers(ready, per, groups);
    tx_gaps = gaps;
    rx_gaps = gaps;
    issued_inodes.delete();
    send_request(FUNC_CLEAR, NUM_W'($urandom_range(0, 4095)));
    span = used_per_group() * used_groups();
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_request(FUNC_ALLOC, NUM_W'($urandom_range(0, 4095)));
        if (last_reply.status == STATUS_OK) issued_inodes.push_back(last_reply.number);
      end else if (pick < 75 && issued_inodes.size() != 0) begin
        slot = $urandom_range(0, issued_inodes.size() - 1);
        send_request(FUNC_FREE, NUM_W'(issued_inodes[slot]));
        issued_inodes.delete(slot);
      end else if (pick < 85 && span != 0) begin
        send_request(pick[0] ? FUNC_MARK : FUNC_FREE, NUM_W'($urandom_range(1, span)));
      end else if (pick < 97) begin
        send_request(pick[0] ? FUNC_MARK : FUNC_FREE, NUM_W'($urandom_range(0, 4095)));
      end else begin
        send_request(FUNC_CLEAR, NUM_W'($urandom_range(0, 4095)));
        issued_inodes.delete();
      end
    end
  endtask

  // Mostly small shapes keep allocs short; one phase each covers a zero
  // size, clamped sizes and group counts, an unmounted spell and the full
  // size. The last phase runs without any idle cycles.
  task automatic test_random_traffic();
    run_random_phase(1'b1, $urandom_range(1, 16), $urandom_range(1, 8), 180, 1'b1);
    run_random_phase(1'b1, 0, $urandom_range(1, 8), 120, 1'b1);
    run_random_phase(1'b1, $urandom_range(17, 48), $urandom_range(1, 4), 180, 1'b0);
    run_random_phase(1'b0, $urandom_range(1, 48), $urandom_range(1, 8), 30, 1'b1);
    run_random_phase(1'b1, $urandom_range(1, 32), $urandom_range(9, 15), 180, 1'b1);
    run_random_phase(1'b1, $urandom_range(257, 511), 1, 100, 1'b1);
    run_random_phase(1'b1, 8, 8, 250, 1'b1);
    run_random_phase(1'b1, $urandom_range(2, 40), $urandom_range(1, 8), 300, 1'b1);
    run_random_phase(1'b1, MAX_PER_GROUP, MAX_GROUPS, 150, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    // The model starts from the allocator's reset state.
    foreach (inode_used[i]) inode_used[i] = 1'b0;
    foreach (group_free[g]) group_free[g] = 0;
    free_total      = 0;
    mounted         = 1'b0;
    per_group_reg   = MAX_PER_GROUP;
    group_count_reg = MAX_GROUPS;
    tx_gaps         = 1'b1;
    rx_gaps         = 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_unmounted();
    test_unloaded_bitmap();
    test_first_fit();
    test_group_shapes();
    test_backpressure();
    test_random_traffic();

    // Everything is sent: wait for the last reply, then watch a while longer
    // for any reply that should not be there.
    wait_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d allocs, %0d frees, %0d clears and %0d marks over shapes",
             requests_by_func[FUNC_ALLOC], requests_by_func[FUNC_FREE],
             requests_by_func[FUNC_CLEAR], requests_by_func[FUNC_MARK]);
    $display("from one to 256 inodes per group; replies: %0d ok, %0d rejected, %0d full.",
             replies_by_status[STATUS_OK], replies_by_status[STATUS_INVALID],
             replies_by_status[STATUS_FULL]);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // A generous bound on the whole run, well beyond the slowest correct one.
  initial begin : run_limit
    #50_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
